// ----- design/dtem_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dtem_pkg;

    localparam int MASK_BITS  = 8;
    localparam int DELAY_BITS = 32;

    typedef struct packed {
        logic                  source;
        logic [MASK_BITS-1:0]  pin_mask;
        logic [MASK_BITS-1:0]  dir_mask;
        logic [MASK_BITS-1:0]  option_bits;
        logic [DELAY_BITS-1:0] delay_ticks;
        logic                  last_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [MASK_BITS-1:0]  out_pins;
        logic [MASK_BITS-1:0]  out_dirs;
        logic [MASK_BITS-1:0]  out_options;
        logic [DELAY_BITS-1:0] out_delay;
        logic                  want_source;
        logic                  run_end;
        logic                  merge_done;
        logic                  dropped;
    } t_out_item;

    typedef struct packed {
        logic [MASK_BITS-1:0]  pins;
        logic [MASK_BITS-1:0]  dirs;
        logic [MASK_BITS-1:0]  opts;
        logic [DELAY_BITS-1:0] dly;
    } t_head;

    typedef struct packed {
        logic wr0;
        logic wr1;
    } t_rq_wr;

endpackage

`default_nettype wire

// ----- design/dtem_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtem_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_acc,
    input  dtem_pkg::t_in_item   i_item,
    output dtem_pkg::t_rq_wr     o_wr,
    output dtem_pkg::t_out_item  o_res0,
    output dtem_pkg::t_out_item  o_res1
);
    import dtem_pkg::*;

    function automatic t_out_item mk_evt(input t_head h);
        t_out_item r;
        r             = '0;
        r.out_pins    = h.pins;
        r.out_dirs    = h.dirs;
        r.out_options = h.opts;
        r.out_delay   = h.dly;
        return r;
    endfunction

    logic [1:0] r_hv, n_hv;
    logic [1:0] r_end, n_end;
    t_head      r_head [2];
    t_head      n_head [2];
    t_head      new_head;
    t_head      eff [2];
    t_head      merged;
    t_head      rest;
    logic       s, o, lt, eq, w, l;
    logic       borrow;
    logic [DELAY_BITS-1:0] d01, d10, diff;
    logic [1:0] onehot;
    logic       want, done;
    t_rq_wr     wr;
    t_out_item  res0, res1;

    always_comb begin
        s             = i_item.source;
        o             = ~s;
        onehot        = s ? 2'b10 : 2'b01;
        new_head.pins = i_item.pin_mask;
        new_head.dirs = i_item.dir_mask;
        new_head.opts = i_item.option_bits;
        new_head.dly  = i_item.delay_ticks;
        eff[0]        = s ? r_head[0] : new_head;
        eff[1]        = s ? new_head : r_head[1];
        {borrow, d01} = {1'b0, eff[0].dly} - {1'b0, eff[1].dly};
        d10           = eff[1].dly - eff[0].dly;
        eq            = (eff[0].dly == eff[1].dly);
        lt            = borrow;
        w             = ~lt;
        l             = lt;
        diff          = lt ? d10 : d01;
        merged.pins   = eff[0].pins | eff[1].pins;
        merged.dirs   = eff[0].dirs | eff[1].dirs;
        merged.opts   = eff[0].opts | eff[1].opts;
        merged.dly    = eff[0].dly;
        rest          = eff[l];
        rest.dly      = diff;

        n_hv   = r_hv;
        n_end  = r_end;
        n_head = r_head;
        wr     = '0;
        res0   = '0;
        res1   = '0;

        if (i_acc) begin
            if (r_hv[s] || r_end[s]) begin
                wr.wr0       = 1'b1;
                res0.dropped = 1'b1;
            end else begin
                n_head[s] = new_head;
                n_end[s]  = r_end[s] | i_item.last_of_stream;
                if (r_hv[o]) begin
                    wr.wr0 = 1'b1;
                    if (eq) begin
                        res0 = mk_evt(merged);
                        n_hv = 2'b00;
                    end else begin
                        res0          = mk_evt(eff[w]);
                        n_head[l].dly = diff;
                        if (n_end[w]) begin
                            res1   = mk_evt(rest);
                            wr.wr1 = 1'b1;
                            n_hv   = 2'b00;
                        end else begin
                            n_hv = l ? 2'b10 : 2'b01;
                        end
                    end
                end else if (r_end[o]) begin
                    wr.wr0 = 1'b1;
                    res0   = mk_evt(new_head);
                    n_hv   = r_hv;
                end else begin
                    n_hv = r_hv | onehot;
                end
            end
        end

        want             = (n_hv[0] | n_end[0]) & ~n_hv[1] & ~n_end[1];
        done             = (n_end == 2'b11) && (n_hv == 2'b00);
        res0.want_source = want;
        res0.merge_done  = done;
        res0.run_end     = ~wr.wr1;
        res1.want_source = want;
        res1.merge_done  = done;
        res1.run_end     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 2'b00;
            r_end <= 2'b00;
        end else begin
            r_hv  <= n_hv;
            r_end <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
    end

    assign o_wr   = wr;
    assign o_res0 = res0;
    assign o_res1 = res1;

endmodule

`default_nettype wire

// ----- design/dtem_rq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtem_rq #(
    parameter int DEPTH = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  dtem_pkg::t_rq_wr     i_wr,
    input  dtem_pkg::t_out_item  i_d0,
    input  dtem_pkg::t_out_item  i_d1,
    input  wire                  i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output dtem_pkg::t_out_item  o_data
);
    import dtem_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    t_out_item     r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp, r_rp, n_rp, wp1;
    logic [CW-1:0] r_count, n_count;
    logic          pop_ok;

    always_comb begin
        wp1     = incr(r_wp);
        pop_ok  = i_pop && (r_count != '0);
        n_rp    = pop_ok ? incr(r_rp) : r_rp;
        n_wp    = r_wp;
        if (i_wr.wr1) begin
            n_wp = incr(wp1);
        end else if (i_wr.wr0) begin
            n_wp = wp1;
        end
        n_count = r_count + CW'(i_wr.wr0) + CW'(i_wr.wr1) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr0) begin
            r_mem[r_wp] <= i_d0;
        end
        if (i_wr.wr1) begin
            r_mem[wp1] <= i_d1;
        end
    end

    assign o_full  = (r_count > CW'(DEPTH - 2));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];

endmodule

`default_nettype wire

// ----- design/delta_time_event_merge.sv -----
// Channel  | Ports                      | Transfer
// ---------+----------------------------+------------------------------
// item in  | i_item, push, full         | push && !full at i_clk rise
// result   | o_result, empty, pop       | pop && !empty at i_clk rise
//
// One item per cycle while full is low; each item yields zero, one or two
// results, which are written into the result queue at the transfer. The
// head compare and subtract are combinational. full rises while fewer than
// two queue entries are free; pop drains one result a cycle while empty is
// low. Synchronous reset empties the heads, ended flags and queue.
`timescale 1ns / 1ps
`default_nettype none

module delta_time_event_merge #(
    parameter int DEPTH = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  dtem_pkg::t_in_item   i_item,
    output logic                 empty,
    input  wire                  pop,
    output dtem_pkg::t_out_item  o_result
);
    import dtem_pkg::*;

    logic      acc;
    logic      rq_full;
    t_rq_wr    wr;
    t_out_item res0, res1;

    assign acc  = push & ~rq_full;
    assign full = rq_full;

    dtem_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_item  (i_item),
        .o_wr    (wr),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    dtem_rq #(
        .DEPTH (DEPTH)
    ) u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_d0    (res0),
        .i_d1    (res1),
        .i_pop   (pop),
        .o_full  (rq_full),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule

`default_nettype wire

// ----- sim/dtem_merge_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtem_merge_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire                  i_full,
    input  dtem_pkg::t_in_item   i_item,
    input  wire                  i_empty,
    input  wire                  i_pop,
    input  dtem_pkg::t_out_item  i_result,
    output int                   o_errors,
    output int                   o_outstanding,
    output logic                 o_want,
    output logic [1:0]           o_heads,
    output logic [dtem_pkg::DELAY_BITS-1:0] o_other_delay
);
    import dtem_pkg::*;

    localparam bit STREAM_A = 1'b0;
    localparam bit STREAM_B = 1'b1;

    logic [1:0] head_live;
    logic [1:0] stream_closed;
    t_head      heads [2];
    t_out_item  merged_events [$];
    int         error_count = 0;
    int         results_seen = 0;

    initial begin
        o_errors = 0;
        o_outstanding = 0;
        o_want = 1'b0;
        o_heads = 2'b00;
        o_other_delay = '0;
    end

    function automatic logic next_wanted();
        logic w;
        w = 1'b0;
        if (!head_live[STREAM_B] && !stream_closed[STREAM_B]) w = STREAM_B;
        if (!head_live[STREAM_A] && !stream_closed[STREAM_A]) w = STREAM_A;
        return w;
    endfunction

    function automatic logic all_emitted();
        return stream_closed == 2'b11 && head_live == 2'b00;
    endfunction

    function automatic t_out_item head_event(input bit h);
        t_out_item r;
        r = '0;
        r.out_pins    = heads[h].pins;
        r.out_dirs    = heads[h].dirs;
        r.out_options = heads[h].opts;
        r.out_delay   = heads[h].dly;
        return r;
    endfunction

    task automatic merge_step(input t_in_item it);
        t_out_item r;
        t_out_item step_out [$];
        bit        s;
        bit        h;
        s = it.source;
        if (head_live[s] || stream_closed[s]) begin
            r = '0;
            r.want_source = next_wanted();
            r.run_end     = 1'b1;
            r.merge_done  = all_emitted();
            r.dropped     = 1'b1;
            merged_events.push_back(r);
            return;
        end
        heads[s].pins = it.pin_mask;
        heads[s].dirs = it.dir_mask;
        heads[s].opts = it.option_bits;
        heads[s].dly  = it.delay_ticks;
        head_live[s] = 1'b1;
        if (it.last_of_stream) stream_closed[s] = 1'b1;
        while (step_out.size() < 2) begin
            if (head_live == 2'b11) begin
                if (heads[STREAM_A].dly == heads[STREAM_B].dly) begin
                    r = head_event(STREAM_A);
                    r.out_pins    |= heads[STREAM_B].pins;
                    r.out_dirs    |= heads[STREAM_B].dirs;
                    r.out_options |= heads[STREAM_B].opts;
                    head_live = 2'b00;
                end else if (heads[STREAM_A].dly < heads[STREAM_B].dly) begin
                    heads[STREAM_B].dly -= heads[STREAM_A].dly;
                    r = head_event(STREAM_A);
                    head_live[STREAM_A] = 1'b0;
                end else begin
                    heads[STREAM_A].dly -= heads[STREAM_B].dly;
                    r = head_event(STREAM_B);
                    head_live[STREAM_B] = 1'b0;
                end
                step_out.push_back(r);
            end else if (head_live != 2'b00) begin
                h = head_live[STREAM_A] ? STREAM_A : STREAM_B;
                if (!stream_closed[~h]) break;
                r = head_event(h);
                head_live[h] = 1'b0;
                step_out.push_back(r);
            end else begin
                break;
            end
        end
        foreach (step_out[k]) begin
            r = step_out[k];
            r.want_source = next_wanted();
            r.run_end     = (k == step_out.size() - 1);
            r.merge_done  = all_emitted();
            r.dropped     = 1'b0;
            merged_events.push_back(r);
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] expd);
        $display("merge check: result %0d %s got %0h expected %0h",
                 results_seen, what, got, expd);
        error_count++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item expd;
        if (merged_events.size() == 0) begin
            report("unexpected result", 32'(got), 0);
            return;
        end
        expd = merged_events.pop_front();
        if (got.out_pins !== expd.out_pins)
            report("out_pins", 32'(got.out_pins), 32'(expd.out_pins));
        if (got.out_dirs !== expd.out_dirs)
            report("out_dirs", 32'(got.out_dirs), 32'(expd.out_dirs));
        if (got.out_options !== expd.out_options)
            report("out_options", 32'(got.out_options), 32'(expd.out_options));
        if (got.out_delay !== expd.out_delay)
            report("out_delay", 32'(got.out_delay), 32'(expd.out_delay));
        if (got.want_source !== expd.want_source)
            report("want_source", 32'(got.want_source), 32'(expd.want_source));
        if (got.run_end !== expd.run_end)
            report("run_end", 32'(got.run_end), 32'(expd.run_end));
        if (got.merge_done !== expd.merge_done)
            report("merge_done", 32'(got.merge_done), 32'(expd.merge_done));
        if (got.dropped !== expd.dropped)
            report("dropped", 32'(got.dropped), 32'(expd.dropped));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_live = 2'b00;
            stream_closed = 2'b00;
            merged_events.delete();
        end else begin
            if (i_pop && !i_empty) begin
                check_result(i_result);
                results_seen++;
            end
            if (i_push && !i_full) merge_step(i_item);
        end
        o_errors      <= error_count;
        o_outstanding <= merged_events.size();
        o_want        <= next_wanted();
        o_heads       <= head_live;
        o_other_delay <= head_live[STREAM_A] ? heads[STREAM_A].dly :
                         head_live[STREAM_B] ? heads[STREAM_B].dly : '0;
    end

endmodule

`default_nettype wire

// ----- sim/delta_time_event_merge_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none

module delta_time_event_merge_tb;
    import dtem_pkg::*;

    localparam bit STREAM_A = 1'b0;
    localparam bit STREAM_B = 1'b1;
    localparam int RANDOM_EVENTS = 2000;
    localparam int TAIL_EVENTS = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [DELAY_BITS-1:0] MAX_DELAY = '1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_item  item_in = '0;
    t_out_item result_out;
    logic      no_idle = 1'b0;
    int        pop_stall = 0;
    int        cycles = 0;
    int        errors;
    int        outstanding;
    logic      want_src;
    logic [1:0] heads_live;
    logic [DELAY_BITS-1:0] pending_delay;

    always #1 i_clk = ~i_clk;

    delta_time_event_merge dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (item_in),
        .empty    (empty),
        .pop      (pop),
        .o_result (result_out)
    );

    dtem_merge_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_item        (item_in),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_result      (result_out),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_want        (want_src),
        .o_heads       (heads_live),
        .o_other_delay (pending_delay)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (no_idle) begin
            pop <= 1'b1;
        end else if (pop_stall > 0) begin
            pop_stall <= pop_stall - 1;
            pop <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            pop_stall <= $urandom_range(0, 5);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic t_in_item step_event(input bit src,
            input logic [MASK_BITS-1:0] pins, dirs, opts,
            input logic [DELAY_BITS-1:0] dly, input bit last);
        t_in_item it;
        it.source         = src;
        it.pin_mask       = pins;
        it.dir_mask       = dirs;
        it.option_bits    = opts;
        it.delay_ticks    = dly;
        it.last_of_stream = last;
        return it;
    endfunction

    function automatic t_in_item random_event(input bit src,
            input logic [DELAY_BITS-1:0] match);
        t_in_item it;
        it.source         = src;
        it.pin_mask       = MASK_BITS'($urandom);
        it.dir_mask       = MASK_BITS'($urandom);
        it.option_bits    = MASK_BITS'($urandom);
        it.last_of_stream = 1'b0;
        case ($urandom_range(0, 7))
            0, 1: it.delay_ticks = $urandom_range(0, 3);
            2, 3: it.delay_ticks = match;
            4: it.delay_ticks = DELAY_BITS'($urandom);
            5: it.delay_ticks = MAX_DELAY;
            6: it.delay_ticks = match + 1'b1;
            default: it.delay_ticks = $urandom_range(0, 255);
        endcase
        return it;
    endfunction

    // enter and leave at a falling edge; hold the item until the transfer
    task automatic send(input t_in_item it);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        push <= 1'b1;
        item_in <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_in_item ev;
        int n;
        bit src;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(step_event(STREAM_A, 8'hff, 8'h00, 8'hff, 0, 1'b0));
        send(step_event(STREAM_B, 8'h00, 8'hff, 8'h00, 0, 1'b0));
        send(step_event(STREAM_A, 8'hff, 8'hff, 8'hff, MAX_DELAY, 1'b0));
        send(step_event(STREAM_A, 8'h00, 8'h00, 8'h00, 1, 1'b0));
        send(step_event(STREAM_B, 8'h01, 8'h80, 8'h55, 5, 1'b0));
        send(step_event(STREAM_B, 8'haa, 8'h55, 8'h0f, MAX_DELAY, 1'b0));
        send(step_event(STREAM_B, 8'h00, 8'h00, 8'h00, 0, 1'b0));
        send(step_event(STREAM_A, 8'h80, 8'h01, 8'hf0, 2, 1'b0));
        send(step_event(STREAM_A, 8'h0f, 8'hf0, 8'haa, 3, 1'b0));
        send(step_event(STREAM_B, 8'h00, 8'h00, 8'h00, 0, 1'b0));
        send(step_event(STREAM_A, 8'h00, 8'h00, 8'h00, 0, 1'b0));
        send(step_event(STREAM_B, 8'h12, 8'h34, 8'h56, 7, 1'b0));
        send(step_event(STREAM_A, 8'h65, 8'h43, 8'h21, 9, 1'b0));
        send(step_event(STREAM_B, 8'hff, 8'h00, 8'h00, 2, 1'b0));

        for (n = 0; n < RANDOM_EVENTS; n++) begin
            no_idle <= ((n / 250) % 4 == 3);
            src = ($urandom_range(0, 7) == 0) ? 1'($urandom) : want_src;
            send(random_event(src, pending_delay));
        end

        // close one stream against the pending head, then run the other out
        no_idle <= 1'b1;
        if (heads_live == 2'b00) send(random_event(want_src, pending_delay));
        src = ~want_src;
        ev = random_event(want_src, pending_delay);
        ev.last_of_stream = 1'b1;
        if (pending_delay == 0 || $urandom_range(0, 1) == 0)
            ev.delay_ticks = pending_delay;
        else
            ev.delay_ticks = $urandom_range(0, pending_delay - 1);
        send(ev);
        for (n = 0; n < TAIL_EVENTS; n++) begin
            ev = random_event(src, pending_delay);
            if (n == 3 || n == TAIL_EVENTS - 1) ev.source = ~src;
            if (n == TAIL_EVENTS - 4) ev.last_of_stream = 1'b1;
            send(ev);
        end
        push <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
